>>> rtl/core/tgfm_pkg.sv
// ----------------------------------------------------------------------------
// Tenengrad focus measure package
// Shared types and constants for the focus measure block.
// ----------------------------------------------------------------------------
package tgfm_pkg;

  localparam int MAX_WIDTH_DEF     = 4096;
  localparam int FRACTION_BITS_DEF = 4;
  localparam int HEIGHT_LIMIT      = 4096;
  localparam int SUM_W             = 39;
  localparam int MEAN_W            = 15;
  localparam int CNT_W             = 24;
  localparam int CFG_W             = 13;
  localparam logic [CFG_W-1:0] WIDTH_RESET  = 13'd640;
  localparam logic [CFG_W-1:0] HEIGHT_RESET = 13'd480;
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  typedef struct packed {
    logic [7:0] pixel;
    logic       start_of_frame;
  } in_beat_t;

  typedef struct packed {
    logic [MEAN_W-1:0] mean_sharpness;
    logic [SUM_W-1:0]  sum_sharpness;
    logic [CNT_W-1:0]  interior_count;
  } out_beat_t;

  // Work item handed from the front end to the back end.
  typedef struct packed {
    logic              has_mag;
    logic [11:0]       gx_abs;
    logic [11:0]       gy_abs;
    logic              clear;
    logic              emit;
    logic [CNT_W-1:0]  count;
  } work_t;

endpackage

>>> rtl/core/tgfm_front.sv
// ----------------------------------------------------------------------------
// Tenengrad front end
// Tracks position, keeps the line stores and window, forms Sobel gradients.
// ----------------------------------------------------------------------------
module tgfm_front import tgfm_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             acc,
  input  in_beat_t         beat,
  input  logic [CFG_W-1:0] width_cfg,
  input  logic [CFG_W-1:0] height_cfg,
  output logic             wvalid,
  output work_t            work
);
  localparam int AW = $clog2(MAX_WIDTH);

  logic [7:0]  up_mem  [MAX_WIDTH];
  logic [7:0]  mid_mem [MAX_WIDTH];
  logic [7:0]  up_rd, mid_rd;
  logic [AW-1:0] rd_addr;

  logic [12:0] col_r, col_nxt, row_r, row_nxt;
  logic [14:0] w, h;
  logic [12:0] c_eff, r_eff;

  // Stage 1 registers.
  logic        s1_v_r;
  logic [7:0]  s1_px_r;
  logic [AW-1:0] s1_a_r;
  logic        s1_int_r, s1_clr_r, s1_emit_r;
  logic [CNT_W-1:0] s1_cnt_r;
  logic [23:0] win0_r, win1_r;
  logic        wvalid_r;
  work_t       work_r;

  always_comb begin
    w = {2'b0, width_cfg};
    if (w < 15'd3) w = 15'd3;
    if (w > 15'(MAX_WIDTH)) w = 15'(MAX_WIDTH);
    h = {2'b0, height_cfg};
    if (h < 15'd3) h = 15'd3;
    if (h > 15'(HEIGHT_LIMIT)) h = 15'(HEIGHT_LIMIT);
    c_eff = beat.start_of_frame ? 13'd0 : col_r;
    r_eff = beat.start_of_frame ? 13'd0 : row_r;
    rd_addr = (32'(c_eff) >= MAX_WIDTH) ? AW'(MAX_WIDTH - 1) : AW'(c_eff);
    col_nxt = c_eff + 13'd1;
    row_nxt = r_eff;
    if (15'(c_eff) >= w - 15'd1) begin
      col_nxt = 13'd0;
      row_nxt = r_eff + 13'd1;
      if (15'(r_eff) >= h - 15'd1) row_nxt = 13'd0;
    end
  end

  // A beat that reads the address written by the beat just before it takes
  // the data being written.
  always_ff @(posedge clk) begin
    if (acc) begin
      if (s1_v_r && (s1_a_r == rd_addr)) begin
        up_rd  <= mid_rd;
        mid_rd <= s1_px_r;
      end else begin
        up_rd  <= up_mem[rd_addr];
        mid_rd <= mid_mem[rd_addr];
      end
    end
    if (s1_v_r) begin
      up_mem[s1_a_r]  <= mid_rd;
      mid_mem[s1_a_r] <= s1_px_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= acc;
      if (acc) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
    end
    if (acc) begin
      s1_px_r   <= beat.pixel;
      s1_a_r    <= rd_addr;
      s1_int_r  <= (r_eff >= 13'd2) && (rd_addr >= AW'(2));
      s1_clr_r  <= beat.start_of_frame;
      s1_emit_r <= (15'(c_eff) >= w - 15'd1) && (15'(r_eff) >= h - 15'd1);
      s1_cnt_r  <= CNT_W'(24'(w - 15'd2) * 24'(h - 15'd2));
    end
  end

  logic [23:0] cur;
  logic [9:0]  lw, rw, tr, br;
  logic [10:0] gx_d, gy_d;
  assign cur = {up_rd, mid_rd, s1_px_r};

  always_comb begin
    lw = 10'(win1_r[23:16]) + {1'b0, win1_r[15:8], 1'b0} + 10'(win1_r[7:0]);
    rw = 10'(cur[23:16]) + {1'b0, cur[15:8], 1'b0} + 10'(cur[7:0]);
    tr = 10'(win1_r[23:16]) + {1'b0, win0_r[23:16], 1'b0} + 10'(cur[23:16]);
    br = 10'(win1_r[7:0]) + {1'b0, win0_r[7:0], 1'b0} + 10'(cur[7:0]);
    gx_d = (rw >= lw) ? 11'(rw - lw) : 11'(lw - rw);
    gy_d = (tr >= br) ? 11'(tr - br) : 11'(br - tr);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win0_r <= '0;
      win1_r <= '0;
      wvalid_r <= 1'b0;
    end else begin
      wvalid_r <= s1_v_r;
      if (s1_v_r) begin
        win1_r <= win0_r;
        win0_r <= cur;
      end
    end
    if (s1_v_r) begin
      work_r.has_mag <= s1_int_r;
      work_r.gx_abs  <= 12'(gx_d);
      work_r.gy_abs  <= 12'(gy_d);
      work_r.clear   <= s1_clr_r;
      work_r.emit    <= s1_emit_r;
      work_r.count   <= s1_cnt_r;
    end
  end

  assign wvalid = wvalid_r;
  assign work   = work_r;
endmodule

>>> rtl/core/tgfm_queue.sv
// ----------------------------------------------------------------------------
// Tenengrad work queue
// Small FIFO that separates the front end from the back end.
// ----------------------------------------------------------------------------
module tgfm_queue import tgfm_pkg::*; #(
  parameter int DEPTH = 8
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  wr,
  input  work_t wdata,
  input  logic  rd,
  output logic  nonempty,
  output logic  almost_full,
  output work_t rdata
);
  localparam int AW = $clog2(DEPTH);
  work_t mem [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (wr) wp_r <= wp_r + AW'(1);
      if (rd) rp_r <= rp_r + AW'(1);
      cnt_r <= cnt_r + (AW+1)'(wr) - (AW+1)'(rd);
    end
    if (wr) mem[wp_r] <= wdata;
  end

  assign rdata       = mem[rp_r];
  assign nonempty    = cnt_r != '0;
  assign almost_full = cnt_r >= (AW+1)'(DEPTH - 4);
endmodule

>>> rtl/core/tgfm_back.sv
// ----------------------------------------------------------------------------
// Tenengrad back end
// Square root per interior pixel, accumulation, and the mean division per frame.
// ----------------------------------------------------------------------------
module tgfm_back import tgfm_pkg::*; #(
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      avail,
  input  work_t     work,
  output logic      take,
  output logic      out_empty,
  input  logic      out_pop,
  output out_beat_t out_data
);
  localparam int SW = 24 + 2*FRACTION_BITS;   // scaled square width
  localparam int RW = SW/2 + 1;              // root width
  localparam int QW = SUM_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_ROOT = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;

  logic [1:0] st_r;
  logic [SW+1:0] rem_r;
  logic [SW-1:0] v_r;
  logic [RW-1:0] res_r;
  logic [5:0]    it_r;
  logic [SUM_W-1:0] sum_r;
  work_t cur_r;
  logic [QW-1:0] q_r;
  logic [QW:0]   drem_r;
  logic [QW-1:0] dnum_r;
  logic          ovalid_r;
  out_beat_t     obuf_r;

  logic [23:0] sq;
  logic [SW-1:0] scaled;
  logic [SW+1:0] trial;
  logic [SW+1:0] rem_sh;
  logic [RW-1:0] root_f;
  logic [SW+1:0] rem_f;
  logic [RW:0]   fin_root;
  logic [SUM_W-1:0] sum_base;
  logic [SUM_W:0]   sum_add;
  logic [SUM_W-1:0] sum_sat;
  logic [QW:0]      dtrial;
  logic             div_done;

  assign sq = 24'(work.gx_abs) * 24'(work.gx_abs) + 24'(work.gy_abs) * 24'(work.gy_abs);
  assign scaled = SW'(sq) << (2*FRACTION_BITS);

  assign take = (st_r == ST_IDLE) && avail && !(work.emit && ovalid_r && !out_pop);

  assign rem_sh = {rem_r[SW-1:0], v_r[SW-1 -: 2]};
  assign trial  = rem_sh - {(SW+2-RW-2)'(0), res_r, 2'b01};

  // Final root bit and round to nearest: m+1 when v > m*m + m, i.e. rem > m.
  always_comb begin
    root_f = !trial[SW+1] ? {res_r[RW-2:0], 1'b1} : {res_r[RW-2:0], 1'b0};
    rem_f  = !trial[SW+1] ? trial : rem_sh;
    fin_root = (rem_f > (SW+2)'(root_f)) ? (RW+1)'(root_f) + (RW+1)'(1) : (RW+1)'(root_f);
  end

  assign sum_base = cur_r.clear ? '0 : sum_r;
  assign sum_add  = {1'b0, sum_base} + (SUM_W+1)'(fin_root);
  assign sum_sat  = sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];
  assign dtrial   = {drem_r[QW-1:0], dnum_r[QW-1]} - (QW+1)'(cur_r.count);
  assign div_done = (st_r == ST_DIV) && (it_r == 6'd1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      sum_r <= '0;
      ovalid_r <= 1'b0;
    end else begin
      if (div_done) ovalid_r <= 1'b1;
      else if (out_pop && ovalid_r) ovalid_r <= 1'b0;
      case (st_r)
        ST_IDLE: begin
          if (take) begin
            cur_r <= work;
            v_r   <= scaled;
            rem_r <= '0;
            res_r <= '0;
            if (work.has_mag) begin
              st_r <= ST_ROOT;
              it_r <= 6'(SW/2);
            end else begin
              st_r <= work.emit ? ST_DIV : ST_IDLE;
              if (work.clear) sum_r <= '0;
              dnum_r <= work.clear ? '0 : sum_r;
              drem_r <= '0;
              it_r   <= 6'(QW);
            end
          end
        end
        ST_ROOT: begin
          v_r <= v_r << 2;
          if (!trial[SW+1]) begin
            rem_r <= trial;
            res_r <= {res_r[RW-2:0], 1'b1};
          end else begin
            rem_r <= rem_sh;
            res_r <= {res_r[RW-2:0], 1'b0};
          end
          // Finish of a root: round, accumulate, maybe begin the mean.
          if (it_r == 6'd1) begin
            sum_r <= sum_sat;
            if (cur_r.emit) begin
              st_r   <= ST_DIV;
              dnum_r <= sum_sat;
              drem_r <= '0;
              it_r   <= 6'(QW);
            end else begin
              st_r <= ST_IDLE;
              it_r <= it_r - 6'd1;
            end
          end else begin
            it_r <= it_r - 6'd1;
          end
        end
        ST_DIV: begin
          dnum_r <= dnum_r << 1;
          if (!dtrial[QW]) begin
            drem_r <= dtrial;
            q_r <= {q_r[QW-2:0], 1'b1};
          end else begin
            drem_r <= {drem_r[QW-1:0], dnum_r[QW-1]};
            q_r <= {q_r[QW-2:0], 1'b0};
          end
          it_r <= it_r - 6'd1;
          if (it_r == 6'd1) begin
            st_r <= ST_IDLE;
            obuf_r.mean_sharpness <= (({q_r[QW-2:0], !dtrial[QW]}) > QW'((1 << MEAN_W) - 1)) ?
                                     {MEAN_W{1'b1}} : MEAN_W'({q_r[QW-2:0], !dtrial[QW]});
            obuf_r.sum_sharpness  <= sum_r;
            obuf_r.interior_count <= cur_r.count;
            sum_r <= '0;
          end
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end

  assign out_empty = !ovalid_r;
  assign out_data  = obuf_r;
endmodule

>>> rtl/core/tenengrad_focus_measure.sv
// ----------------------------------------------------------------------------
// Tenengrad focus measure
// A frame result passes through two front stages, the queue, 16 root steps and
// 39 divide steps after the last pixel beat when the back end is idle.
// The back end takes no new pixel while it works out a root, so the queue
// fills and in_full stalls the input.
// Reset is synchronous and active low; line stores are not cleared.
// ----------------------------------------------------------------------------
module tenengrad_focus_measure import tgfm_pkg::*; #(
  parameter int MAX_WIDTH     = MAX_WIDTH_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_push,
  output logic             in_full,
  input  in_beat_t         in_data,
  output logic             out_empty,
  input  logic             out_pop,
  output out_beat_t        out_data,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);
  logic [CFG_W-1:0] width_r, height_r;
  logic wvalid, nonempty, almost_full, take, acc;
  work_t fwork, qwork;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RESET;
      height_r <= HEIGHT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WIDTH:  width_r  <= cfg_data;
        REG_HEIGHT: height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_full = almost_full;
  assign acc = in_push && !in_full;

  tgfm_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk, .rst_n, .acc, .beat(in_data), .width_cfg(width_r), .height_cfg(height_r),
    .wvalid, .work(fwork)
  );

  tgfm_queue #(.DEPTH(8)) u_queue (
    .clk, .rst_n, .wr(wvalid), .wdata(fwork), .rd(take),
    .nonempty, .almost_full, .rdata(qwork)
  );

  tgfm_back #(.FRACTION_BITS(FRACTION_BITS)) u_back (
    .clk, .rst_n, .avail(nonempty), .work(qwork), .take,
    .out_empty, .out_pop, .out_data
  );
endmodule

>>> rtl/core/tgfm_checker.sv
// ----------------------------------------------------------------------------
// Tenengrad port checker
// Checks result beats seen on the top-level ports.
// ----------------------------------------------------------------------------
module tgfm_checker import tgfm_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      out_empty,
  input logic      out_pop,
  input out_beat_t out_data
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> !out_empty && $stable(out_data))
    else $error("result beat dropped or changed while stalled");
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> out_data.interior_count != '0)
    else $error("zero interior count");
  a_mean: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> 54'(out_data.mean_sharpness) <= 54'(out_data.sum_sharpness)
                   || out_data.mean_sharpness == {MEAN_W{1'b1}})
    else $error("mean above sum");
endmodule

bind tenengrad_focus_measure tgfm_checker u_chk (
  .clk, .rst_n, .out_empty, .out_pop, .out_data
);

>>> bench/tb.sv
// ----------------------------------------------------------------------------
// Tenengrad focus measure testbench
// Streams small grayscale frames through the block with random stalls on both
// sides and checks every frame result against a bit-accurate predictor.
// ----------------------------------------------------------------------------
import tgfm_pkg::*;

class focus_scoreboard;
  logic [7:0]  line_top [4096];
  logic [7:0]  line_mid [4096];
  logic [23:0] col_prev0, col_prev1;
  int unsigned col_pos, row_pos;
  longint unsigned mag_sum;
  int unsigned width_reg, height_reg;
  out_beat_t   pending_frames[$];
  int          errors;
  int          frames_seen;

  function new();
    col_prev0 = '0;
    col_prev1 = '0;
    col_pos = 0;
    row_pos = 0;
    mag_sum = 0;
    width_reg = 640;
    height_reg = 480;
    errors = 0;
    frames_seen = 0;
    foreach (line_top[i]) begin
      line_top[i] = '0;
      line_mid[i] = '0;
    end
  endfunction

  function void set_reg(logic idx, int unsigned val);
    if (idx == REG_WIDTH) width_reg = val & 13'h1fff;
    else height_reg = val & 13'h1fff;
  endfunction

  function longint unsigned round_root(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function int weigh(logic [23:0] col);
    return int'(col[23:16]) + 2 * int'(col[15:8]) + int'(col[7:0]);
  endfunction

  function void note_pixel(in_beat_t beat);
    int unsigned w, h, c;
    logic [23:0] cur;
    int gx, gy;
    longint unsigned sq, m;
    out_beat_t res;
    longint unsigned cnt, mean;
    w = width_reg < 3 ? 3 : (width_reg > 4096 ? 4096 : width_reg);
    h = height_reg < 3 ? 3 : (height_reg > 4096 ? 4096 : height_reg);
    if (beat.start_of_frame) begin
      col_pos = 0;
      row_pos = 0;
      mag_sum = 0;
    end
    c = col_pos > 4095 ? 4095 : col_pos;
    cur = {line_top[c], line_mid[c], beat.pixel};
    if (row_pos >= 2 && c >= 2) begin
      gx = weigh(cur) - weigh(col_prev1);
      gy = (int'(col_prev1[23:16]) + 2 * int'(col_prev0[23:16]) + int'(cur[23:16]))
         - (int'(col_prev1[7:0]) + 2 * int'(col_prev0[7:0]) + int'(cur[7:0]));
      sq = longint'(gx * gx + gy * gy) << 8;
      m = round_root(sq);
      if (sq > m * m + m) m = m + 1;
      mag_sum = mag_sum + m;
      if (mag_sum > (64'd1 << 39) - 1) mag_sum = (64'd1 << 39) - 1;
    end
    line_top[c] = cur[15:8];
    line_mid[c] = beat.pixel;
    col_prev1 = col_prev0;
    col_prev0 = cur;
    if (col_pos >= w - 1 && row_pos >= h - 1) begin
      cnt = longint'(w - 2) * longint'(h - 2);
      mean = mag_sum / cnt;
      if (mean > 32767) mean = 32767;
      res.mean_sharpness = mean[14:0];
      res.sum_sharpness = mag_sum[38:0];
      res.interior_count = cnt[23:0];
      pending_frames.push_back(res);
      col_pos = 0;
      row_pos = 0;
      mag_sum = 0;
    end else if (col_pos >= w - 1) begin
      col_pos = 0;
      row_pos = row_pos + 1;
    end else begin
      col_pos = col_pos + 1;
    end
  endfunction

  function void check_frame(out_beat_t got);
    out_beat_t exp;
    if (pending_frames.size() == 0) begin
      $display("%0t: unexpected result %h", $time, got);
      errors++;
      return;
    end
    exp = pending_frames.pop_front();
    frames_seen++;
    if (got.mean_sharpness !== exp.mean_sharpness) begin
      $display("%0t: mean expected %0d actual %0d", $time, exp.mean_sharpness,
               got.mean_sharpness);
      errors++;
    end
    if (got.sum_sharpness !== exp.sum_sharpness) begin
      $display("%0t: sum expected %0d actual %0d", $time, exp.sum_sharpness,
               got.sum_sharpness);
      errors++;
    end
    if (got.interior_count !== exp.interior_count) begin
      $display("%0t: count expected %0d actual %0d", $time, exp.interior_count,
               got.interior_count);
      errors++;
    end
  endfunction
endclass

module tb;
  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_push = 1'b0;
  logic             in_full;
  in_beat_t         in_data = '0;
  logic             out_empty;
  logic             out_pop = 1'b0;
  out_beat_t        out_data;
  logic             cfg_we = 1'b0;
  logic             cfg_index = REG_WIDTH;
  logic [CFG_W-1:0] cfg_data = '0;

  focus_scoreboard  frame_board;
  bit               calm_mode = 1'b0;
  bit               sof_pending = 1'b0;
  int               pixels_sent = 0;
  int               cycle_count = 0;
  int               width_now = 640;
  int               height_now = 480;

  tenengrad_focus_measure u_top (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 2000000) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("** tenengrad_focus_measure: FAILED **");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) frame_board.check_frame(out_data);
    out_pop <= calm_mode ? 1'b1 : ($urandom_range(99) >= 26);
  end

  // The first beat after a size change always starts a new frame.
  task automatic send_pixel(logic [7:0] px, logic sof);
    logic sof_now;
    sof_now = sof | sof_pending;
    sof_pending = 1'b0;
    while (!calm_mode && $urandom_range(99) < 26) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push <= 1'b1;
    in_data <= '{pixel: px, start_of_frame: sof_now};
    @(posedge clk);
    while (in_full) @(posedge clk);
    frame_board.note_pixel('{pixel: px, start_of_frame: sof_now});
    pixels_sent++;
  endtask

  task automatic drain_results();
    in_push <= 1'b0;
    while (frame_board.pending_frames.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    frame_board.set_reg(idx, val);
    @(posedge clk);
  endtask

  task automatic set_size(int w, int h);
    drain_results();
    write_reg(REG_WIDTH, w[CFG_W-1:0]);
    write_reg(REG_HEIGHT, h[CFG_W-1:0]);
    width_now = w < 3 ? 3 : (w > 4096 ? 4096 : w);
    height_now = h < 3 ? 3 : (h > 4096 ? 4096 : h);
    sof_pending = 1'b1;
  endtask

  task automatic send_frame(int kind);
    int n;
    logic [7:0] px;
    n = width_now * height_now;
    for (int i = 0; i < n; i++) begin
      case (kind)
        0: px = 8'($urandom_range(255));
        1: px = (i % 2) ? 8'hff : 8'h00;
        2: px = ((i / width_now) % 2) ? 8'hff : 8'h00;
        default: px = $urandom_range(1) ? 8'hff : 8'h00;
      endcase
      send_pixel(px, i == 0 && $urandom_range(1));
    end
  endtask

  initial begin
    frame_board = new();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_size(3, 3);
    for (int i = 0; i < 9; i++) send_pixel((i % 2) ? 8'hff : 8'h00, i == 0);
    for (int i = 0; i < 9; i++) send_pixel(i == 4 ? 8'hff : 8'h00, 1'b0);
    set_size(1, 0);
    send_frame(3);
    set_size(4, 3);
    send_frame(1);
    send_frame(2);

    calm_mode = 1'b1;
    set_size(8, 6);
    repeat (3) send_frame(0);
    calm_mode = 1'b0;

    while (pixels_sent < 820) begin
      set_size($urandom_range(3, 9), $urandom_range(3, 7));
      repeat ($urandom_range(1, 3)) begin
        if ($urandom_range(9) == 0) begin
          repeat ($urandom_range(1, width_now * 2))
            send_pixel(8'($urandom_range(255)), 1'b0);
          send_frame(0);
          for (int i = 1; i < width_now * height_now; i++)
            send_pixel(8'($urandom_range(255)), 1'b0);
        end else begin
          send_frame($urandom_range(3));
        end
      end
    end

    drain_results();
    write_reg(REG_WIDTH, 13'd640);
    write_reg(REG_HEIGHT, 13'd480);

    $display("sent %0d pixels, checked %0d frame results over sizes 3x3 to 9x7",
             pixels_sent, frame_board.frames_seen);
    $display("with clamped register values, misaligned frames and both sides stalling");
    if (frame_board.errors == 0 && frame_board.pending_frames.size() == 0) begin
      $display("** tenengrad_focus_measure: PASSED **");
    end else begin
      $display("** tenengrad_focus_measure: FAILED **");
    end
    $finish;
  end
endmodule
